// ===== rtl/glzw_pkg.sv =====
// Package for the GIF LZW code generator: field widths, item structs and
// small helper functions (clear code, index mask, bit length).
// No dependencies.
`default_nettype none

package glzw_pkg;

  localparam int unsigned CODE_W        = 12;
  localparam int unsigned WIDTH_W       = 4;
  localparam int unsigned PIX_W         = 8;
  localparam int unsigned MINB_W        = 4;
  localparam int unsigned CLR_W         = 9;
  localparam int unsigned MAX_CODES_DEF = 4096;
  localparam int unsigned ALPHABET_DEF  = 256;
  localparam int unsigned IN_DEPTH      = 4;
  localparam int unsigned OUT_DEPTH     = 4;

  localparam logic [MINB_W-1:0] MIN_BITS_RST = 4'd8;

  // One pixel after index classification
  typedef struct packed {
    logic             last;
    logic [PIX_W-1:0] pix;
  } pix_item_t;

  // One emitted code
  typedef struct packed {
    logic               eof;
    logic [WIDTH_W-1:0] width;
    logic [CODE_W-1:0]  code;
  } code_item_t;

  // Clamp the code size register to 1..8
  function automatic logic [MINB_W-1:0] eff_bits(input logic [MINB_W-1:0] m);
    logic [MINB_W-1:0] r;
    r = m;
    if (m == '0) begin
      r = MINB_W'(1);
    end else if (m > MINB_W'(8)) begin
      r = MINB_W'(8);
    end
    return r;
  endfunction

  function automatic logic [CLR_W-1:0] clear_code(input logic [MINB_W-1:0] m);
    return CLR_W'(1) << eff_bits(m);
  endfunction

  function automatic logic [PIX_W-1:0] index_mask(input logic [MINB_W-1:0] m);
    logic [CLR_W-1:0] c;
    c = clear_code(m) - CLR_W'(1);
    return c[PIX_W-1:0];
  endfunction

  // Position of the highest set bit plus one
  function automatic logic [WIDTH_W-1:0] bitlog(input logic [CODE_W-1:0] v);
    logic [WIDTH_W-1:0] n;
    n = '0;
    for (int i = 0; i < CODE_W; i++) begin
      if (v[i]) begin
        n = WIDTH_W'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/glzw_fifo.sv =====
// Small synchronous FIFO with registered storage, used between the parts
// of the LZW code generator. No dependencies.
`default_nettype none

module glzw_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers and count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/glzw_front.sv =====
// Front end of the LZW code generator: accepts pixels, masks and saturates
// the palette index, and queues the item. Depends on glzw_pkg, glzw_fifo.
`default_nettype none

module glzw_front #(
  parameter int unsigned ALPHABET_SIZE = glzw_pkg::ALPHABET_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [glzw_pkg::MINB_W-1:0] min_bits_i,
  input  logic                        pix_valid_i,
  output logic                        pix_ready_o,
  input  logic [glzw_pkg::PIX_W-1:0]  pix_i,
  input  logic                        last_i,
  output logic                        head_valid_o,
  output glzw_pkg::pix_item_t         head_o,
  input  logic                        pop_i
);

  import glzw_pkg::*;

  localparam logic [PIX_W:0]   ALPHA_LIM = (PIX_W + 1)'(ALPHABET_SIZE);
  localparam logic [PIX_W-1:0] ALPHA_TOP = PIX_W'(ALPHABET_SIZE - 1);

  logic [PIX_W-1:0] masked;
  pix_item_t        item;
  logic             full;
  logic [$bits(pix_item_t)-1:0] head_bits;

  // Mask to the code size, then saturate to the alphabet
  always_comb begin
    masked    = pix_i & index_mask(min_bits_i);
    item.last = last_i;
    item.pix  = masked;
    if ({1'b0, masked} >= ALPHA_LIM) begin
      item.pix = ALPHA_TOP;
    end
  end

  assign pix_ready_o = !full;

  glzw_fifo #(
    .WIDTH ($bits(pix_item_t)),
    .DEPTH (IN_DEPTH)
  ) u_in_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (pix_valid_i),
    .data_i  (item),
    .full_o  (full),
    .pop_i   (pop_i),
    .valid_o (head_valid_o),
    .data_o  (head_bits)
  );

  assign head_o = pix_item_t'(head_bits);

endmodule

`default_nettype wire

// ===== rtl/glzw_core.sv =====
// Back end of the LZW code generator: dictionary lookup, entry insertion,
// clear, flush and end codes. Holds the dictionary and its reverse map.
// Depends on glzw_pkg.
`default_nettype none

module glzw_core #(
  parameter int unsigned MAX_CODES     = glzw_pkg::MAX_CODES_DEF,
  parameter int unsigned ALPHABET_SIZE = glzw_pkg::ALPHABET_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [glzw_pkg::MINB_W-1:0] cfg_wdata_i,
  input  logic [glzw_pkg::MINB_W-1:0] min_bits_i,
  input  logic                        head_valid_i,
  input  glzw_pkg::pix_item_t         head_i,
  output logic                        pop_o,
  input  logic                        out_full_i,
  output logic                        push_o,
  output glzw_pkg::code_item_t        push_item_o
);

  import glzw_pkg::*;

  localparam int unsigned CBITS      = $clog2(MAX_CODES);
  localparam int unsigned ABITS      = $clog2(ALPHABET_SIZE);
  localparam int unsigned DBITS      = CBITS + ABITS;
  localparam int unsigned DICT_DEPTH = MAX_CODES << ABITS;

  localparam logic [CBITS-1:0] ONE       = CBITS'(1);
  localparam logic [CBITS-1:0] TWO       = CBITS'(2);
  localparam logic [CBITS-1:0] NEXT_MAX  = CBITS'(MAX_CODES - 2);
  localparam logic [CBITS-1:0] NEXT_RST  = CBITS'(clear_code(MIN_BITS_RST)) + TWO;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REV,
    S_DEC,
    S_CLR,
    S_FLUSH,
    S_END
  } state_e;

  // Dictionary: key -> code; reverse map: code -> key that created it.
  // An entry counts only if its code lies in the live range and the
  // reverse map points back at the same key, so no clearing is needed.
  logic [CBITS-1:0] dict_mem [DICT_DEPTH];
  logic [DBITS-1:0] rev_mem  [MAX_CODES];
  logic [CBITS-1:0] dict_rd_q;
  logic [DBITS-1:0] rev_rd_q;

  state_e           state_q, state_d;
  logic [CBITS-1:0] prefix_q, prefix_d;
  logic [CBITS-1:0] next_q, next_d;
  logic             have_q, have_d;
  logic [DBITS-1:0] idx_q, idx_d;
  logic [ABITS-1:0] p_q, p_d;
  logic             last_q, last_d;
  logic [CBITS-1:0] c_q, c_d;
  logic             fwd_q, fwd_d;
  logic [CBITS-1:0] fwd_code_q, fwd_code_d;

  logic [CBITS-1:0] clr, clr_new, next_m1, c_sel, prefix_new;
  logic [DBITS-1:0] rd_addr;
  logic [ABITS-1:0] head_p;
  logic             dict_re, add_we, rev_re, hit, done;

  assign clr     = CBITS'(clear_code(min_bits_i));
  assign clr_new = CBITS'(clear_code(cfg_wdata_i));
  assign next_m1 = next_q - ONE;
  assign head_p  = head_i.pix[ABITS-1:0];
  assign c_sel   = fwd_q ? fwd_code_q : dict_rd_q;
  assign rev_re  = (state_q == S_REV);

  // Sequence lookups and code emission
  always_comb begin
    state_d     = state_q;
    prefix_d    = prefix_q;
    next_d      = next_q;
    have_d      = have_q;
    idx_d       = idx_q;
    p_d         = p_q;
    last_d      = last_q;
    c_d         = c_q;
    fwd_d       = 1'b0;
    fwd_code_d  = fwd_code_q;
    pop_o       = 1'b0;
    push_o      = 1'b0;
    push_item_o = '0;
    dict_re     = 1'b0;
    add_we      = 1'b0;
    rd_addr     = {prefix_q, head_p};
    hit         = 1'b0;
    done        = 1'b0;
    prefix_new  = prefix_q;

    case (state_q)
      S_IDLE: begin
        if (cfg_we_i) begin
          have_d = 1'b0;
          next_d = clr_new + TWO;
        end else if (head_valid_i) begin
          pop_o  = 1'b1;
          p_d    = head_p;
          last_d = head_i.last;
          if (!have_q) begin
            prefix_d = CBITS'(head_p);
            have_d   = 1'b1;
            state_d  = head_i.last ? S_FLUSH : S_IDLE;
          end else begin
            dict_re = 1'b1;
            idx_d   = rd_addr;
            state_d = S_REV;
          end
        end
      end

      S_REV: begin
        c_d     = c_sel;
        state_d = S_DEC;
      end

      S_DEC: begin
        if ((c_q >= clr + TWO) && (c_q < next_q) && (rev_rd_q == idx_q)) begin
          hit = 1'b1;
        end
        if (hit) begin
          prefix_new = c_q;
          done       = 1'b1;
        end else if (!out_full_i) begin
          push_o            = 1'b1;
          push_item_o.code  = CODE_W'(prefix_q);
          push_item_o.width = bitlog(CODE_W'(next_m1));
          prefix_new        = CBITS'(p_q);
          if (next_q > NEXT_MAX) begin
            prefix_d = prefix_new;
            state_d  = S_CLR;
          end else begin
            add_we = 1'b1;
            next_d = next_q + ONE;
            done   = 1'b1;
          end
        end
        // Chain straight into the next lookup when a pixel waits
        if (done) begin
          prefix_d = prefix_new;
          rd_addr  = {prefix_new, head_p};
          if (last_q) begin
            state_d = S_FLUSH;
          end else if (head_valid_i) begin
            pop_o      = 1'b1;
            p_d        = head_p;
            last_d     = head_i.last;
            dict_re    = 1'b1;
            idx_d      = rd_addr;
            fwd_d      = add_we && (rd_addr == idx_q);
            fwd_code_d = next_q;
            state_d    = S_REV;
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      S_CLR: begin
        if (!out_full_i) begin
          push_o            = 1'b1;
          push_item_o.code  = CODE_W'(clr);
          push_item_o.width = bitlog(CODE_W'(next_m1));
          next_d            = clr + TWO;
          state_d           = last_q ? S_FLUSH : S_IDLE;
        end
      end

      S_FLUSH: begin
        if (!out_full_i) begin
          push_o            = 1'b1;
          push_item_o.code  = CODE_W'(prefix_q);
          push_item_o.width = bitlog(CODE_W'(next_m1));
          state_d           = S_END;
        end
      end

      S_END: begin
        if (!out_full_i) begin
          push_o            = 1'b1;
          push_item_o.code  = CODE_W'(clr + ONE);
          push_item_o.width = bitlog(CODE_W'(next_q));
          push_item_o.eof   = 1'b1;
          next_d            = clr + TWO;
          have_d            = 1'b0;
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      prefix_q   <= '0;
      next_q     <= NEXT_RST;
      have_q     <= 1'b0;
      idx_q      <= '0;
      p_q        <= '0;
      last_q     <= 1'b0;
      c_q        <= '0;
      fwd_q      <= 1'b0;
      fwd_code_q <= '0;
    end else begin
      state_q    <= state_d;
      prefix_q   <= prefix_d;
      next_q     <= next_d;
      have_q     <= have_d;
      idx_q      <= idx_d;
      p_q        <= p_d;
      last_q     <= last_d;
      c_q        <= c_d;
      fwd_q      <= fwd_d;
      fwd_code_q <= fwd_code_d;
    end
  end

  // Dictionary memory
  always_ff @(posedge clk_i) begin
    if (add_we) begin
      dict_mem[idx_q] <= next_q;
    end
    if (dict_re) begin
      dict_rd_q <= dict_mem[rd_addr];
    end
  end

  // Reverse map memory
  always_ff @(posedge clk_i) begin
    if (add_we) begin
      rev_mem[next_q] <= idx_q;
    end
    if (rev_re) begin
      rev_rd_q <= rev_mem[c_sel];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gif_lzw_code_generator.sv =====
// Channel   | Signals                          | Item
// ----------+----------------------------------+-------------------------------
// s_axis    | tvalid tready tdata[7:0] tlast   | pixel_index, last_pixel
// m_axis    | tvalid tready tdata[15:0] tlast  | code_value, code_width, eof
// cfg       | cfg_we_i cfg_wdata_i[3:0]        | min_code_bits
//
// Back to back, a pixel passes the back end as a reverse-map read, then a decision
// chained with the next dictionary read; from idle a dictionary read comes first.
// A frame's first pixel only loads the prefix; a full table adds the clear-code state,
// the last pixel the flush and end states. No clearing pass after reset: entries are
// checked against the reverse map. A 4-deep queue on each side lets input and output
// stall independently; a full output queue holds the back end.
`default_nettype none

module gif_lzw_code_generator #(
  parameter int unsigned MAX_CODES     = glzw_pkg::MAX_CODES_DEF,
  parameter int unsigned ALPHABET_SIZE = glzw_pkg::ALPHABET_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // cfg
  input  logic                        cfg_we_i,
  input  logic [glzw_pkg::MINB_W-1:0] cfg_wdata_i,
  // pixels in
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // [7:0] pixel_index
  input  logic                        s_axis_tlast,  // last_pixel
  // codes out
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [15:0]                 m_axis_tdata,  // [11:0] code_value, [15:12] code_width
  output logic                        m_axis_tlast   // end_of_frame
);

  import glzw_pkg::*;

  logic [MINB_W-1:0] min_bits_q;
  logic              head_valid, pop;
  pix_item_t         head;
  logic              code_push, out_full;
  code_item_t        code_item;
  logic [$bits(code_item_t)-1:0] out_bits;
  code_item_t        out_item;

  // Code size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_bits_q <= MIN_BITS_RST;
    end else if (cfg_we_i) begin
      min_bits_q <= cfg_wdata_i;
    end
  end

  glzw_front #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .min_bits_i   (min_bits_q),
    .pix_valid_i  (s_axis_tvalid),
    .pix_ready_o  (s_axis_tready),
    .pix_i        (s_axis_tdata),
    .last_i       (s_axis_tlast),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  glzw_core #(
    .MAX_CODES     (MAX_CODES),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .min_bits_i   (min_bits_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_full_i   (out_full),
    .push_o       (code_push),
    .push_item_o  (code_item)
  );

  // Output queue decouples code emission from the sink
  glzw_fifo #(
    .WIDTH ($bits(code_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (code_push),
    .data_i  (code_item),
    .full_o  (out_full),
    .pop_i   (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .data_o  (out_bits)
  );

  assign out_item     = code_item_t'(out_bits);
  assign m_axis_tdata = {out_item.width, out_item.code};
  assign m_axis_tlast = out_item.eof;

`ifndef SYNTHESIS
  // Core never pushes into a full output queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(code_push && out_full))
    else $error("code pushed into full output queue");

  // End code is always clear plus one
  a_end_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |->
      (m_axis_tdata[11:0] == CODE_W'(clear_code(min_bits_q)) + CODE_W'(1)))
    else $error("end code value mismatch");

  // Width stays in range
  a_width_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[15:12] >= WIDTH_W'(2)) && (m_axis_tdata[15:12] <= WIDTH_W'(CODE_W)))
    else $error("code width out of range");

  // Code fits in its width
  a_code_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[11:0] >> m_axis_tdata[15:12]) == '0))
    else $error("code value wider than its width");
`endif

endmodule

`default_nettype wire
